FILE: rtl/tccw_pkg.sv
// shared types and constants of the text console character writer
package tccw_pkg;

  // fixed field widths
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;

  // control characters and reset attribute
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // command codes on the input side
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;

  // classified operation
  typedef enum logic [2:0] {
    OP_READ,
    OP_IGNORE,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_PRINT
  } op_t;

  // one queued item
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] chr;
    logic [IDX_W-1:0]  idx;
  } item_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_RESP
  } st_t;

endpackage

FILE: rtl/tccw_front.sv
// front end: accepts input items and classifies them for the queue
module tccw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // char_code[7:0], cell_index[18:8]
  input  logic                        s_tuser,   // cmd
  input  logic                        clearing,
  input  logic                        q_full,
  output logic                        push,
  output tccw_pkg::item_t             push_item
);

  logic            f_valid;
  tccw_pkg::item_t f_item;
  tccw_pkg::item_t cls;
  logic [tccw_pkg::CHAR_W-1:0] chr;

  assign chr = s_tdata[7:0];

  // classify the incoming item
  always_comb begin
    cls.chr = chr;
    cls.idx = s_tdata[18:8];
    if (s_tuser == tccw_pkg::CMD_READ) begin
      cls.op = tccw_pkg::OP_READ;
    end else if (chr == tccw_pkg::CH_CR) begin
      cls.op = tccw_pkg::OP_IGNORE;
    end else if (chr == tccw_pkg::CH_LF) begin
      cls.op = tccw_pkg::OP_NEWLINE;
    end else if (chr == tccw_pkg::CH_BS) begin
      cls.op = tccw_pkg::OP_BACKSPACE;
    end else begin
      cls.op = tccw_pkg::OP_PRINT;
    end
  end

  // handshake with the queue
  assign push      = f_valid && !q_full;
  assign s_tready  = !clearing && (!f_valid || !q_full);
  assign push_item = f_item;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      f_item <= cls;
    end
  end

endmodule

FILE: rtl/tccw_fifo.sv
// short queue of classified items between front and back
module tccw_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tccw_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output tccw_pkg::item_t q_item
);

  localparam int PW = $clog2(tccw_pkg::QDEPTH);
  localparam int NW = $clog2(tccw_pkg::QDEPTH + 1);

  tccw_pkg::item_t slots [tccw_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full    = (count == NW'(tccw_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(tccw_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(tccw_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/tccw_back.sv
// back end: screen memory, cursor, scroll sequencer and result register
module tccw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            q_valid,
  input  tccw_pkg::item_t q_item,
  output logic            pop,
  output logic            clearing,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata
);

  localparam int NCELLS      = COLS * ROWS;
  localparam int AW          = $clog2(NCELLS);
  localparam int POSW        = (AW > tccw_pkg::POS_W) ? AW : tccw_pkg::POS_W;
  localparam int CW          = $clog2(COLS);
  localparam int RW          = $clog2(ROWS + 1);
  localparam int MW          = tccw_pkg::ATTR_W + tccw_pkg::CHAR_W;
  localparam int LAST_COPY   = NCELLS - COLS - 1;
  localparam int BLANK_START = NCELLS - COLS;

  tccw_pkg::st_t   state, state_next;
  tccw_pkg::item_t item;
  logic [AW-1:0]   cnt;
  logic            cp_valid;
  logic [AW-1:0]   cp_addr;
  logic [CW-1:0]   col, col_next;
  logic [RW-1:0]   row, row_next;
  logic [tccw_pkg::ATTR_W-1:0] attr;
  logic [tccw_pkg::CHAR_W-1:0] res_char;
  logic [tccw_pkg::ATTR_W-1:0] res_attr;

  logic [MW-1:0]   mem [NCELLS];
  logic [MW-1:0]   rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [MW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [POSW-1:0] pos;
  logic            scroll;
  logic            in_range;
  logic            slot_free;

  assign clearing  = (state == tccw_pkg::ST_CLEAR);
  assign slot_free = !m_tvalid || m_tready;
  assign pos       = POSW'(row) * POSW'(COLS) + POSW'(col);
  assign in_range  = (POSW'(item.idx) < POSW'(NCELLS));

  // cursor update for a put
  always_comb begin
    col_next = col;
    row_next = row;
    case (item.op)
      tccw_pkg::OP_NEWLINE: begin
        col_next = '0;
        row_next = row + RW'(1);
      end
      tccw_pkg::OP_BACKSPACE: begin
        if (pos != '0) begin
          if (col == '0) begin
            col_next = CW'(COLS - 1);
            row_next = row - RW'(1);
          end else begin
            col_next = col - CW'(1);
          end
        end
      end
      tccw_pkg::OP_PRINT: begin
        if (col == CW'(COLS - 1)) begin
          col_next = '0;
          row_next = row + RW'(1);
        end else begin
          col_next = col + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign scroll = (row_next == RW'(ROWS));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tccw_pkg::ST_CLEAR: begin
        if (cnt == AW'(NCELLS - 1)) state_next = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (q_valid) state_next = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        if (item.op == tccw_pkg::OP_READ) begin
          state_next = tccw_pkg::ST_READ;
        end else if (scroll) begin
          state_next = tccw_pkg::ST_COPY;
        end else begin
          state_next = tccw_pkg::ST_RESP;
        end
      end
      tccw_pkg::ST_READ: state_next = tccw_pkg::ST_RESP;
      tccw_pkg::ST_COPY: begin
        if (cnt == AW'(LAST_COPY)) state_next = tccw_pkg::ST_BLANK;
      end
      tccw_pkg::ST_BLANK: begin
        if (!cp_valid && cnt == AW'(NCELLS - 1)) state_next = tccw_pkg::ST_RESP;
      end
      tccw_pkg::ST_RESP: begin
        if (slot_free) state_next = tccw_pkg::ST_IDLE;
      end
      default: state_next = tccw_pkg::ST_IDLE;
    endcase
  end

  // memory port and queue control
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = {attr, {tccw_pkg::CHAR_W{1'b0}}};
    mem_raddr = '0;
    case (state)
      tccw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = {tccw_pkg::ATTR_RESET, {tccw_pkg::CHAR_W{1'b0}}};
      end
      tccw_pkg::ST_IDLE: begin
        pop = q_valid;
      end
      tccw_pkg::ST_EXEC: begin
        mem_raddr = item.idx[AW-1:0];
        case (item.op)
          tccw_pkg::OP_NEWLINE: begin
            mem_we = 1'b1;
          end
          tccw_pkg::OP_BACKSPACE: begin
            mem_we    = (pos != '0);
            mem_waddr = AW'(pos - POSW'(1));
          end
          tccw_pkg::OP_PRINT: begin
            mem_we    = 1'b1;
            mem_wdata = {attr, item.chr};
          end
          default: begin
          end
        endcase
      end
      tccw_pkg::ST_COPY: begin
        mem_raddr = AW'(cnt + AW'(COLS));
        mem_we    = cp_valid;
        mem_waddr = cp_addr;
        mem_wdata = rd_data;
      end
      tccw_pkg::ST_BLANK: begin
        mem_we = 1'b1;
        if (cp_valid) begin
          mem_waddr = cp_addr;
          mem_wdata = rd_data;
        end else begin
          mem_waddr = cnt;
        end
      end
      default: begin
      end
    endcase
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tccw_pkg::ST_CLEAR;
      cnt      <= '0;
      cp_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
      attr     <= tccw_pkg::ATTR_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cp_valid <= (state == tccw_pkg::ST_COPY);
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      // result valid: load on a free slot, drop once taken
      if (state == tccw_pkg::ST_RESP && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        tccw_pkg::ST_CLEAR: cnt <= cnt + AW'(1);
        tccw_pkg::ST_EXEC: begin
          cnt <= '0;
          if (item.op != tccw_pkg::OP_READ) begin
            col <= col_next;
            row <= scroll ? RW'(ROWS - 1) : row_next;
          end
        end
        tccw_pkg::ST_COPY: begin
          cnt <= (cnt == AW'(LAST_COPY)) ? AW'(BLANK_START) : cnt + AW'(1);
        end
        tccw_pkg::ST_BLANK: begin
          if (!cp_valid) cnt <= cnt + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (state == tccw_pkg::ST_IDLE && q_valid) begin
      item <= q_item;
    end
    if (state == tccw_pkg::ST_COPY) begin
      cp_addr <= cnt;
    end
    if (state == tccw_pkg::ST_EXEC) begin
      res_char <= '0;
      res_attr <= '0;
    end
    if (state == tccw_pkg::ST_READ) begin
      res_char <= in_range ? rd_data[tccw_pkg::CHAR_W-1:0] : '0;
      res_attr <= in_range ? rd_data[MW-1:tccw_pkg::CHAR_W] : '0;
    end
    if (state == tccw_pkg::ST_RESP && slot_free) begin
      m_tdata <= {5'b0, res_attr, res_char, pos[tccw_pkg::POS_W-1:0]};
    end
  end

endmodule

FILE: rtl/text_console_char_writer.sv
// Character-cell text console of COLS x ROWS cells with a cursor. A put item
// passes in the back end through a queue pop, an execute step with at most
// one cell write, and the result; a read item adds a step for the registered
// memory read. A put that runs the cursor past the bottom row adds a scroll
// through the single write port of the screen memory: every cell below the
// first row is copied up one row, then the last row is blanked. After reset
// a clearing pass blanks the screen and no item is accepted until it ends;
// configuration writes are taken throughout. The front end keeps accepting
// items into a four-entry queue while the back end is busy, and a finished
// result waits in the output register.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // default_attr
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,     // char_code[7:0], cell_index[18:8]
  input  logic        s_tuser,     // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata      // cursor_pos[10:0], cell_char[18:11], cell_attr[26:19]
);

  logic            clearing;
  logic            q_full;
  logic            push;
  tccw_pkg::item_t push_item;
  logic            pop;
  logic            q_valid;
  tccw_pkg::item_t q_item;

  // input classification
  tccw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // item queue
  tccw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // screen and cursor
  tccw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
